// ===== src/bgrb_pkg.sv =====
`default_nettype none

package bgrb_pkg;

	localparam int FONT_ADDR_W = 13;
	localparam int ROW_ADDR_W  = 24;
	localparam int MASK_W      = 16;
	localparam int CFG_DATA_W  = 12;
	localparam int CFG_IDX_W   = 3;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INK_COLOR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CODE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_COUNT = 3'd5;

	typedef struct packed {
		logic                   op;
		logic [FONT_ADDR_W-1:0] font_addr;
		logic [7:0]             font_byte;
		logic [7:0]             char_code;
		logic                   first_of_string;
	} in_t;

	typedef struct packed {
		logic [ROW_ADDR_W-1:0] row_addr;
		logic [MASK_W-1:0]     pixel_mask;
		logic [7:0]            pixel_value;
		logic                  last;
	} out_t;

	typedef struct packed {
		logic                   en;
		logic [FONT_ADDR_W-1:0] addr;
		logic [7:0]             data;
	} store_wr_t;

endpackage

`default_nettype wire

// ===== src/bgrb_glyph_store.sv =====
`default_nettype none

module bgrb_glyph_store #(
	parameter int ROW_BYTES = 2,
	parameter int ROWS      = 3072
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire bgrb_pkg::store_wr_t                 wr,
	input  wire logic [$clog2(ROWS)-1:0]             rd_addr,
	output logic      [ROW_BYTES*8-1:0]              rd_data
);

	localparam int AW     = bgrb_pkg::FONT_ADDR_W;
	localparam int RAW    = $clog2(ROWS);
	localparam int LANE_W = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
	// ceiling reciprocal is exact for every byte address of AW bits
	localparam int RECIP  = ((2 ** AW) + ROW_BYTES - 1) / ROW_BYTES;
	localparam int RECIP_W = AW + 1;

	logic [AW+RECIP_W-1:0] prod;
	logic                  en_s1;
	logic [AW-1:0]         addr_s1;
	logic [7:0]            data_s1;
	logic [RAW-1:0]        row_s1;
	logic [AW-1:0]         lane_full;
	logic [LANE_W-1:0]     lane;
	logic [7:0]            lane_rd_q [ROW_BYTES];

	assign prod = (AW+RECIP_W)'(wr.addr) * (AW+RECIP_W)'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
		end else begin
			en_s1 <= wr.en;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= wr.addr;
		data_s1 <= wr.data;
		row_s1  <= prod[AW +: RAW];
	end

	assign lane_full = addr_s1 - AW'(32'(row_s1) * ROW_BYTES);
	assign lane      = lane_full[LANE_W-1:0];

	for (genvar b = 0; b < ROW_BYTES; b++) begin : g_lane
		logic [7:0] mem [ROWS];

		always_ff @(posedge clk) begin
			if (en_s1 && lane == LANE_W'(b)) begin
				mem[row_s1] <= data_s1;
			end
			lane_rd_q[b] <= mem[rd_addr];
		end
	end

	always_comb begin
		for (int b = 0; b < ROW_BYTES; b++) begin
			rd_data[8*b +: 8] = lane_rd_q[b];
		end
	end

endmodule

`default_nettype wire

// ===== src/bitmap_glyph_row_blitter_core.sv =====
`default_nettype none

// Text overlay engine: turns character codes into frame-buffer row writes.
// Input channel (in_valid / in_stall, payload in_data) carries two kinds of
// transaction. A load stores one font byte into the glyph store; loads are
// taken one per cycle and produce nothing. A draw gives one character code;
// the block places it at the current string position (cleared by
// first_of_string, then advanced by one) and emits GLYPH_HEIGHT transactions
// on the output channel (out_valid / out_stall, payload out_data), one per
// glyph row: frame-buffer address, pixel mask (MSB of each font byte is the
// lowest pixel), ink color and a last flag on the final row.
// A draw of a loaded code holds in_stall high from acceptance until its
// last row is taken into the output register. The base address is formed
// in S_BASE0 and S_BASE1; then one row per cycle while out_stall does not
// hold, limited by the single row adder and the one read port of the glyph store.
// Codes outside the loaded range advance the position and emit nothing.
// Output stall freezes the row sequencer; the pending row is held in the
// output register. Reset clears the string position and the output valid
// and presets the configuration registers; the glyph store is not cleared.
// Issue configuration writes (cfg_wr_en) only while the block is idle.

module bitmap_glyph_row_blitter_core #(
	parameter int GLYPH_WIDTH  = 16,
	parameter int GLYPH_HEIGHT = 24,
	parameter int MAX_GLYPHS   = 128
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire bgrb_pkg::in_t                      in_data,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output bgrb_pkg::out_t                          out_data,
	input  wire logic                               cfg_wr_en,
	input  wire logic [bgrb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [bgrb_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int ROW_BYTES   = GLYPH_WIDTH / 8;
	localparam int ROWS        = MAX_GLYPHS * GLYPH_HEIGHT;
	localparam int RAW         = $clog2(ROWS);
	localparam int STORE_BYTES = ROWS * ROW_BYTES;
	localparam int ROW_W       = $clog2(GLYPH_HEIGHT);
	localparam int AW          = bgrb_pkg::ROW_ADDR_W;
	localparam int MW          = bgrb_pkg::MASK_W;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_BASE0 = 4'b0010,
		S_BASE1 = 4'b0100,
		S_ROW   = 4'b1000
	} state_t;

	state_t               state_q;
	logic [11:0]          frame_width_q;
	logic [11:0]          origin_x_q;
	logic [11:0]          origin_y_q;
	logic [7:0]           ink_color_q;
	logic [7:0]           first_code_q;
	logic [7:0]           glyph_count_q;
	logic [7:0]           str_pos_q;
	logic [AW-1:0]        mul_q;
	logic [AW-1:0]        off_q;
	logic [AW-1:0]        acc_q;
	logic [RAW-1:0]       rd_addr_q;
	logic [ROW_W-1:0]     row_q;
	logic                 out_valid_q;
	bgrb_pkg::out_t       out_q;

	logic                 in_acc;
	logic                 draw_acc;
	logic [7:0]           pos;
	logic [8:0]           code_diff;
	logic                 in_range;
	logic [AW-1:0]        add_a;
	logic [AW-1:0]        add_b;
	logic [AW-1:0]        sum;
	logic                 row_adv;
	logic                 last_row;
	logic [RAW-1:0]       rd_addr;
	logic [GLYPH_WIDTH-1:0] rd_data;
	logic [MW-1:0]        row_mask;
	bgrb_pkg::store_wr_t  store_wr;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign draw_acc  = in_acc && (in_data.op == bgrb_pkg::OP_DRAW);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign pos       = in_data.first_of_string ? 8'd0 : str_pos_q;
	assign code_diff = {1'b0, in_data.char_code} - {1'b0, first_code_q};
	assign in_range  = !code_diff[8] && (code_diff[7:0] < glyph_count_q)
		&& (32'(code_diff[7:0]) < MAX_GLYPHS);

	assign store_wr.en   = in_acc && (in_data.op == bgrb_pkg::OP_LOAD)
		&& (32'(in_data.font_addr) < STORE_BYTES);
	assign store_wr.addr = in_data.font_addr;
	assign store_wr.data = in_data.font_byte;

	// shared adder: base address in two passes, then one pitch step per row
	always_comb begin
		unique case (state_q)
			S_BASE0: begin
				add_a = mul_q;
				add_b = AW'(origin_x_q);
			end
			S_BASE1: begin
				add_a = acc_q;
				add_b = off_q;
			end
			default: begin
				add_a = acc_q;
				add_b = AW'(frame_width_q);
			end
		endcase
	end
	assign sum = add_a + add_b;

	assign row_adv  = (state_q == S_ROW) && (!out_valid_q || !out_stall);
	assign last_row = (row_q == ROW_W'(GLYPH_HEIGHT - 1));
	// fetch the next row in the same edge that the current one leaves
	assign rd_addr  = (row_adv && !last_row) ? rd_addr_q + 1'b1 : rd_addr_q;

	bgrb_glyph_store #(
		.ROW_BYTES (ROW_BYTES),
		.ROWS      (ROWS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (store_wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	for (genvar i = 0; i < MW; i++) begin : g_mask
		if (i < GLYPH_WIDTH) begin : g_bit
			assign row_mask[i] = rd_data[i ^ 7];
		end else begin : g_pad
			assign row_mask[i] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= 12'd320;
			origin_x_q    <= 12'd0;
			origin_y_q    <= 12'd0;
			ink_color_q   <= 8'd255;
			first_code_q  <= 8'd32;
			glyph_count_q <= 8'd0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				bgrb_pkg::CFG_FRAME_WIDTH: frame_width_q <= cfg_data;
				bgrb_pkg::CFG_ORIGIN_X:    origin_x_q    <= cfg_data;
				bgrb_pkg::CFG_ORIGIN_Y:    origin_y_q    <= cfg_data;
				bgrb_pkg::CFG_INK_COLOR:   ink_color_q   <= cfg_data[7:0];
				bgrb_pkg::CFG_FIRST_CODE:  first_code_q  <= cfg_data[7:0];
				bgrb_pkg::CFG_GLYPH_COUNT: glyph_count_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			str_pos_q   <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (draw_acc) begin
						str_pos_q <= pos + 8'd1;
						if (in_range) begin
							state_q <= S_BASE0;
						end
					end
				end
				S_BASE0: state_q <= S_BASE1;
				S_BASE1: state_q <= S_ROW;
				S_ROW: begin
					if (row_adv) begin
						out_valid_q <= 1'b1;
						if (last_row) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (draw_acc) begin
			mul_q     <= AW'(frame_width_q) * AW'(origin_y_q);
			off_q     <= AW'(pos) * AW'(GLYPH_WIDTH);
			rd_addr_q <= RAW'(32'(code_diff[7:0]) * GLYPH_HEIGHT);
			row_q     <= '0;
		end
		if (state_q == S_BASE0 || state_q == S_BASE1 || row_adv) begin
			acc_q <= sum;
		end
		if (row_adv) begin
			out_q.row_addr    <= acc_q;
			out_q.pixel_mask  <= row_mask;
			out_q.pixel_value <= ink_color_q;
			out_q.last        <= last_row;
			row_q             <= row_q + 1'b1;
			rd_addr_q         <= rd_addr;
		end
	end

	a_last_row_idle: assert property (@(posedge clk) disable iff (!arst_n)
		row_adv && last_row |=> state_q == S_IDLE)
		else $error("sequencer did not return to idle after the last row");

	a_rows_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_ROW))
		else $error("output transaction raised outside the row state");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ROW && !row_adv |=> $stable(acc_q) && $stable(rd_addr_q))
		else $error("row sequencer moved while the output was stalled");

	// a held last row may only belong to the previous character
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.last && state_q == S_ROW |-> row_q == '0)
		else $error("last row flag shown while rows remain");

endmodule

`default_nettype wire
